// ===== sv/rmq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants of the rotation matrix to quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int FRAC_BITS_DEF = 14;

	// Magnitude of an off-diagonal sum or difference of two 16-bit elements.
	localparam int MAG_W = 17;

	// Branch codes reported on branch_used.
	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_R1C1  = 2'd1;
	localparam logic [1:0] BR_R2C2  = 2'd2;
	localparam logic [1:0] BR_R3C3  = 2'd3;

	// Control that travels with each request down the cell chains.
	typedef struct packed {
		logic       valid;
		logic [1:0] branch;
	} ctl_t;

endpackage

// ===== sv/rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix in signed fixed point to a unit quaternion.
// ----------------------------------------------------------------------------
// Usage:
// A request carries the nine matrix elements m_rXcY (signed, FRAC_BITS
// fraction bits) on a valid/ready input channel. The result channel returns
// quat_w/x/y/z, saturated to +-1.0, and branch_used, which tells which of
// the four classic branches (positive trace, or largest diagonal) was taken.
// The datapath is one prepare stage, a chain of square-root cells (one root
// bit per cell, QW cells), one stage that forms the numerators, a chain of
// division cells (one quotient bit per cell, NW = FRAC_BITS+18 cells, three
// lanes each) and the output register.
// Throughput is one request per cycle while the receiver does not stall:
// every cell hands its partial result to its neighbor whenever the chain
// moves, so requests in flight are only bounded by the chain length.
// When the receiver stalls, the whole chain holds and in_ready drops; it
// rises again in the cycle the result is taken. Reset clears all valid bits,
// so the block comes out of reset empty and ready.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] m_r1c1,
	input  logic signed [15:0] m_r1c2,
	input  logic signed [15:0] m_r1c3,
	input  logic signed [15:0] m_r2c1,
	input  logic signed [15:0] m_r2c2,
	input  logic signed [15:0] m_r2c3,
	input  logic signed [15:0] m_r3c1,
	input  logic signed [15:0] m_r3c2,
	input  logic signed [15:0] m_r3c3,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] quat_w,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z,
	output logic [1:0]         branch_used
);

	// Width of the clamped radicand t; t stays below 2^F + 2^17.
	localparam int TW  = (FRAC_BITS >= 17) ? FRAC_BITS + 2 : 19;
	localparam int RW  = TW + FRAC_BITS + 2;
	localparam int RW2 = RW + (RW % 2);
	localparam int QW  = RW2 / 2;
	localparam int MW  = rmq_pkg::MAG_W;
	localparam int NW  = FRAC_BITS + 18;
	localparam int SSW = 3 + 3 * MW;
	localparam int DSW = 4 + QW;
	localparam int VW  = FRAC_BITS + 18;
	localparam logic [TW:0] ONE_T = (TW + 1)'(1) << FRAC_BITS;
	localparam logic [NW-1:0] ONE_N = NW'(1) << FRAC_BITS;

	logic en;

	// Prepare stage: branch choice, radicand and the three off-diagonal terms.
	logic signed [17:0] trace, comb;
	logic signed [TW:0] tsum;
	logic [1:0]         br;
	logic signed [17:0] dl [3];
	logic [MW-1:0]      mag [3];
	logic [2:0]         sgn;
	logic [TW-1:0]      tcl;

	function automatic logic signed [17:0] sx(input logic signed [15:0] v);
		return 18'(v);
	endfunction

	always_comb begin
		trace = sx(m_r1c1) + sx(m_r2c2) + sx(m_r3c3);
		if (trace > 0) begin
			br = rmq_pkg::BR_TRACE;
		end else if (m_r1c1 > m_r2c2 && m_r1c1 > m_r3c3) begin
			br = rmq_pkg::BR_R1C1;
		end else if (m_r2c2 > m_r3c3) begin
			br = rmq_pkg::BR_R2C2;
		end else begin
			br = rmq_pkg::BR_R3C3;
		end
		// Lanes hold the non-dominant components in w, x, y, z order.
		case (br)
			rmq_pkg::BR_TRACE: begin
				comb  = trace;
				dl[0] = sx(m_r3c2) - sx(m_r2c3);
				dl[1] = sx(m_r1c3) - sx(m_r3c1);
				dl[2] = sx(m_r2c1) - sx(m_r1c2);
			end
			rmq_pkg::BR_R1C1: begin
				comb  = sx(m_r1c1) - sx(m_r2c2) - sx(m_r3c3);
				dl[0] = sx(m_r3c2) - sx(m_r2c3);
				dl[1] = sx(m_r1c2) + sx(m_r2c1);
				dl[2] = sx(m_r1c3) + sx(m_r3c1);
			end
			rmq_pkg::BR_R2C2: begin
				comb  = sx(m_r2c2) - sx(m_r1c1) - sx(m_r3c3);
				dl[0] = sx(m_r1c3) - sx(m_r3c1);
				dl[1] = sx(m_r1c2) + sx(m_r2c1);
				dl[2] = sx(m_r2c3) + sx(m_r3c2);
			end
			default: begin
				comb  = sx(m_r3c3) - sx(m_r1c1) - sx(m_r2c2);
				dl[0] = sx(m_r2c1) - sx(m_r1c2);
				dl[1] = sx(m_r1c3) + sx(m_r3c1);
				dl[2] = sx(m_r2c3) + sx(m_r3c2);
			end
		endcase
		tsum = (TW + 1)'(comb) + $signed(ONE_T);
		// A negative radicand only comes from a matrix that is not a rotation.
		tcl  = tsum[TW] ? '0 : tsum[TW-1:0];
		for (int k = 0; k < 3; k++) begin
			sgn[k] = dl[k][17];
			mag[k] = dl[k][17] ? MW'(-dl[k]) : dl[k][MW-1:0];
		end
	end

	rmq_pkg::ctl_t      ctl_s1;
	logic [RW2-1:0]     rad_s1;
	logic [SSW-1:0]     side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid  <= in_valid;
			ctl_s1.branch <= br;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1  <= RW2'({tcl, (FRAC_BITS + 2)'(0)});
			side_s1 <= {sgn, mag[2], mag[1], mag[0]};
		end
	end

	// Square-root chain.
	rmq_pkg::ctl_t      sq_ctl  [QW+1];
	logic [QW:0]        sq_rem  [QW+1];
	logic [QW-1:0]      sq_root [QW+1];
	logic [RW2-1:0]     sq_rad  [QW+1];
	logic [SSW-1:0]     sq_side [QW+1];

	assign sq_ctl[0]  = ctl_s1;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0]  = rad_s1;
	assign sq_side[0] = side_s1;

	for (genvar i = 0; i < QW; i++) begin : g_sqrt
		rmq_sqrt_cell #(.QW(QW), .RW2(RW2), .SW(SSW)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.ctl_d (sq_ctl[i]),
			.rem_d (sq_rem[i]),
			.root_d(sq_root[i]),
			.rad_d (sq_rad[i]),
			.side_d(sq_side[i]),
			.ctl_q (sq_ctl[i+1]),
			.rem_q (sq_rem[i+1]),
			.root_q(sq_root[i+1]),
			.rad_q (sq_rad[i+1]),
			.side_q(sq_side[i+1])
		);
	end

	// Numerator stage: (mag << F) + sq/2 gives round-half-away division.
	logic [QW-1:0]  sq;
	logic [SSW-1:0] sside;
	logic [NW-1:0]  numv [3];

	always_comb begin
		sq    = sq_root[QW];
		sside = sq_side[QW];
		for (int k = 0; k < 3; k++) begin
			numv[k] = (NW'(sside[k*MW +: MW]) << FRAC_BITS) + NW'(sq >> 1);
		end
	end

	rmq_pkg::ctl_t  ctl_s2;
	logic [QW-1:0]  den_s2;
	logic [NW-1:0]  num_s2 [3];
	logic [DSW-1:0] side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= sq_ctl[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s2  <= sq;
			num_s2  <= numv;
			side_s2 <= {sside[SSW-1 -: 3], sq == '0, sq >> 2};
		end
	end

	// Division chain.
	rmq_pkg::ctl_t  dv_ctl  [NW+1];
	logic [QW-1:0]  dv_den  [NW+1];
	logic [QW-1:0]  dv_rem  [NW+1][3];
	logic [NW-1:0]  dv_num  [NW+1][3];
	logic [NW-1:0]  dv_quo  [NW+1][3];
	logic [DSW-1:0] dv_side [NW+1];

	assign dv_ctl[0]  = ctl_s2;
	assign dv_den[0]  = den_s2;
	assign dv_side[0] = side_s2;
	for (genvar k = 0; k < 3; k++) begin : g_lane0
		assign dv_rem[0][k] = '0;
		assign dv_num[0][k] = num_s2[k];
		assign dv_quo[0][k] = '0;
	end

	for (genvar i = 0; i < NW; i++) begin : g_div
		rmq_div_cell #(.QW(QW), .NW(NW), .SW(DSW)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.ctl_d (dv_ctl[i]),
			.den_d (dv_den[i]),
			.rem_d (dv_rem[i]),
			.num_d (dv_num[i]),
			.quo_d (dv_quo[i]),
			.side_d(dv_side[i]),
			.ctl_q (dv_ctl[i+1]),
			.den_q (dv_den[i+1]),
			.rem_q (dv_rem[i+1]),
			.num_q (dv_num[i+1]),
			.quo_q (dv_quo[i+1]),
			.side_q(dv_side[i+1])
		);
	end

	// Output stage: saturate, restore signs and place the dominant component.
	logic [DSW-1:0]      fside;
	logic                fzero;
	logic [NW-1:0]       bigv;
	logic signed [VW-1:0] lane [3];
	logic signed [VW-1:0] bigs;
	logic [NW-1:0]       qm;
	logic [1:0]          fbr;
	logic signed [VW-1:0] vw, vx, vy, vz;

	always_comb begin
		fside = dv_side[NW];
		fbr   = dv_ctl[NW].branch;
		fzero = fside[QW];
		bigv  = NW'(fside[QW-1:0]);
		bigs  = (bigv > ONE_N) ? VW'(ONE_N) : VW'(bigv);
		for (int k = 0; k < 3; k++) begin
			qm      = fzero ? '0 : ((dv_quo[NW][k] > ONE_N) ? ONE_N : dv_quo[NW][k]);
			lane[k] = fside[QW+1+k] ? -VW'(qm) : VW'(qm);
		end
		case (fbr)
			rmq_pkg::BR_TRACE: begin
				vw = bigs;    vx = lane[0]; vy = lane[1]; vz = lane[2];
			end
			rmq_pkg::BR_R1C1: begin
				vw = lane[0]; vx = bigs;    vy = lane[1]; vz = lane[2];
			end
			rmq_pkg::BR_R2C2: begin
				vw = lane[0]; vx = lane[1]; vy = bigs;    vz = lane[2];
			end
			default: begin
				vw = lane[0]; vx = lane[1]; vy = lane[2]; vz = bigs;
			end
		endcase
	end

	logic out_valid_q;

	// The chain moves whenever the output register is free or being emptied.
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_ctl[NW].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat_w      <= vw[15:0];
			quat_x      <= vx[15:0];
			quat_y      <= vy[15:0];
			quat_z      <= vz[15:0];
			branch_used <= fbr;
		end
	end

`ifndef SYNTHESIS
	// The block only refuses a request while a result is held back.
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("in_ready low without a stalled result");

	// The dominant component of the trace branch is a square root, never negative.
	a_trace_w_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && branch_used == rmq_pkg::BR_TRACE && FRAC_BITS <= 14)
		|-> (quat_w >= 0))
		else $error("negative w in trace branch");

	// The x and y components are saturated to plus or minus one.
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && FRAC_BITS <= 14) |->
		(quat_x <= (16'sd1 <<< FRAC_BITS) && quat_x >= -(16'sd1 <<< FRAC_BITS) &&
		 quat_y <= (16'sd1 <<< FRAC_BITS) && quat_y >= -(16'sd1 <<< FRAC_BITS)))
		else $error("component outside saturation range");
`endif

endmodule

// ===== sv/rmq_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One digit of a restoring integer square root; takes two radicand bits.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell #(
	parameter int QW  = 18,
	parameter int RW2 = 36,
	parameter int SW  = 54
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  rmq_pkg::ctl_t        ctl_d,
	input  logic [QW:0]          rem_d,
	input  logic [QW-1:0]        root_d,
	input  logic [RW2-1:0]       rad_d,
	input  logic [SW-1:0]        side_d,
	output rmq_pkg::ctl_t        ctl_q,
	output logic [QW:0]          rem_q,
	output logic [QW-1:0]        root_q,
	output logic [RW2-1:0]       rad_q,
	output logic [SW-1:0]        side_q
);

	logic [QW+2:0] rem_sh;
	logic [QW+2:0] trial;
	logic [QW+2:0] diff;
	logic          ge;

	always_comb begin
		rem_sh = {rem_d, rad_d[RW2-1 -: 2]};
		trial  = {1'b0, root_d, 2'b01};
		ge     = rem_sh >= trial;
		diff   = rem_sh - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[QW:0] : rem_sh[QW:0];
			root_q <= {root_d[QW-2:0], ge};
			rad_q  <= {rad_d[RW2-3:0], 2'b00};
			side_q <= side_d;
		end
	end

endmodule

// ===== sv/rmq_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div_cell
// One quotient bit of a restoring division, for three lanes sharing a divisor.
// ----------------------------------------------------------------------------
module rmq_div_cell #(
	parameter int QW = 18,
	parameter int NW = 32,
	parameter int SW = 22
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  rmq_pkg::ctl_t        ctl_d,
	input  logic [QW-1:0]        den_d,
	input  logic [QW-1:0]        rem_d [3],
	input  logic [NW-1:0]        num_d [3],
	input  logic [NW-1:0]        quo_d [3],
	input  logic [SW-1:0]        side_d,
	output rmq_pkg::ctl_t        ctl_q,
	output logic [QW-1:0]        den_q,
	output logic [QW-1:0]        rem_q [3],
	output logic [NW-1:0]        num_q [3],
	output logic [NW-1:0]        quo_q [3],
	output logic [SW-1:0]        side_q
);

	logic [QW:0] sh   [3];
	logic [QW:0] diff [3];
	logic        ge   [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sh[k]   = {rem_d[k], num_d[k][NW-1]};
			ge[k]   = sh[k] >= {1'b0, den_d};
			diff[k] = sh[k] - {1'b0, den_d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				rem_q[k] <= ge[k] ? diff[k][QW-1:0] : sh[k][QW-1:0];
				num_q[k] <= {num_d[k][NW-2:0], 1'b0};
				quo_q[k] <= {quo_d[k][NW-2:0], ge[k]};
			end
			den_q  <= den_d;
			side_q <= side_d;
		end
	end

endmodule
